@@ design/distance_weighted_smoothing_filter_defines.svh @@
// assertion macros shared by the filter rtl
`ifndef DISTANCE_WEIGHTED_SMOOTHING_FILTER_DEFINES_SVH
`define DISTANCE_WEIGHTED_SMOOTHING_FILTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DWSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define DWSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");
`define DWSF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define DWSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DWSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define DWSF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ design/dwsf_pkg.sv @@
`timescale 1ns / 1ps
package dwsf_pkg;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_PIXEL_BITS = 8;
    localparam int DEF_MAX_RADIUS = 8;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 8;
    localparam int PIX_PORT_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SIZE_W     = 9;
    localparam int RAD_W      = 4;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 9'd256;
    localparam logic [RAD_W-1:0]  RST_RADIUS = 4'd4;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PASS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RESP   = 8'b0000_0010,
        S_PIX    = 8'b0000_0100,
        S_WIN    = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_DSTART = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_WB     = 8'b1000_0000
    } t_state;
endpackage

@@ design/dwsf_frame_buf.sv @@
`timescale 1ns / 1ps
module dwsf_frame_buf #(
    parameter int DEPTH = 65536,
    parameter int DW    = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/dwsf_div.sv @@
`timescale 1ns / 1ps
module dwsf_div #(
    parameter int DEN_W = 16,
    parameter int QB    = 9,
    localparam int NW   = DEN_W + QB,
    localparam int CW   = $clog2(QB + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NW-1:0]    i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QB-1:0]    o_quo
);
    logic [NW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_dsh;
    logic [QB-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          ge;

    // one quotient bit per cycle, restoring
    assign ge    = (r_rem >= r_dsh);
    assign n_rem = ge ? (r_rem - r_dsh) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= NW'(i_den) << (QB - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[QB-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

@@ design/distance_weighted_smoothing_filter.sv @@
`timescale 1ns / 1ps
`include "distance_weighted_smoothing_filter_defines.svh"
// Image smoothing block with two frame buffers, one current and one spare.
// Input channel (i_in_valid / o_in_ready) takes one command item: write a
// pixel, read a pixel, or run one smoothing pass. Every item gives exactly one
// result item on the output channel (o_out_valid / i_out_ready) carrying the
// read pixel and a coordinate error flag.
// Write and read access the buffer in the accept cycle; the read data is
// registered and loaded into the output register in S_RESP once it is free.
// A pass walks every pixel; each pixel goes through a setup state, one read
// per window pixel (up to (2*radius)^2), the drain and divider start states,
// the divider and a write-back.
// The pass reads the current buffer, writes the spare one, then swaps them.
// Config writes (i_cfg_wr_en, i_cfg_idx, i_cfg_data) take effect at once and
// belong to idle periods only.
// Reset clears control state, makes buffer A current and loads the register
// defaults; buffer contents are undefined until written.
// A stalled receiver holds the result in the output register; the next
// command is taken meanwhile and waits to deliver its result until it frees.
module distance_weighted_smoothing_filter
    import dwsf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [COORD_W-1:0]    i_col,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [PIX_PORT_W-1:0] i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_PORT_W-1:0] o_pixel_out,
    output logic                  o_coord_error
);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int PW     = $clog2(MAXDIM + 1) + 1;
    localparam int WGT_W  = $clog2(2 * MAX_RADIUS + 1);
    localparam int CNT_W  = WGT_W + 2 * $clog2(2 * MAX_RADIUS + 1) + 1;
    localparam int SUM_W  = CNT_W + PIXEL_BITS;
    localparam int QB     = PIXEL_BITS + 1;
    localparam int DEN_W  = CNT_W + 1;
    localparam int NW     = DEN_W + QB;

    t_state r_state;

    logic [SIZE_W-1:0] r_cfg_w, r_cfg_h;
    logic [RAD_W-1:0]  r_cfg_r;
    logic [PW-1:0]     eff_w, eff_h, eff_r;

    logic              r_cur;
    logic [CMD_W-1:0]  r_cmd;
    logic              r_err;
    logic              r_out_valid;
    logic [PIX_PORT_W-1:0] r_pixel_out;
    logic              r_coord_err;

    logic [PW-1:0] r_x, r_y, r_i, r_j;
    logic [PW-1:0] r_x0, r_x1m, r_y1m;
    logic          r_acc_v;
    logic [WGT_W-1:0] r_wgt;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;

    logic          accept, in_range, out_free, last_pix, last_win;
    logic [PW-1:0] x0, x1, y0, y1, dx, dy;
    logic [PW:0]   wgt_full;
    logic [AW-1:0] cmd_addr, win_addr, pix_addr;

    logic                  mem_re, mem_we;
    logic [AW-1:0]         mem_raddr, mem_waddr;
    logic [PIXEL_BITS-1:0] mem_wdata, rd_a, rd_b, rd_data;
    logic                  we_a, we_b;

    logic                  div_done;
    logic [QB-1:0]         div_quo;
    logic [NW-1:0]         div_num;
    logic [DEN_W-1:0]      div_den;

    // effective register values after clamping
    assign eff_w = (16'(r_cfg_w) > 16'(MAX_WIDTH))  ? PW'(MAX_WIDTH)  : PW'(r_cfg_w);
    assign eff_h = (16'(r_cfg_h) > 16'(MAX_HEIGHT)) ? PW'(MAX_HEIGHT) : PW'(r_cfg_h);
    assign eff_r = (r_cfg_r == '0) ? PW'(1) :
                   ((16'(r_cfg_r) > 16'(MAX_RADIUS)) ? PW'(MAX_RADIUS) : PW'(r_cfg_r));

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_range   = (16'(i_col) < 16'(eff_w)) && (16'(i_row) < 16'(eff_h));

    assign cmd_addr = AW'(32'(i_row) * 32'(MAX_WIDTH) + 32'(i_col));
    assign win_addr = AW'(32'(r_j) * 32'(MAX_WIDTH) + 32'(r_i));
    assign pix_addr = AW'(32'(r_y) * 32'(MAX_WIDTH) + 32'(r_x));

    // clipped window bounds for the pixel at (r_x, r_y)
    assign x0 = (r_x > eff_r) ? (r_x - eff_r) : '0;
    assign y0 = (r_y > eff_r) ? (r_y - eff_r) : '0;
    assign x1 = ((r_x + eff_r) > eff_w) ? eff_w : (r_x + eff_r);
    assign y1 = ((r_y + eff_r) > eff_h) ? eff_h : (r_y + eff_r);

    assign dx       = (r_i >= r_x) ? (r_i - r_x) : (r_x - r_i);
    assign dy       = (r_j >= r_y) ? (r_j - r_y) : (r_y - r_j);
    assign wgt_full = {eff_r, 1'b0} - (PW+1)'(dx) - (PW+1)'(dy);

    assign last_win = (r_i == r_x1m) && (r_j == r_y1m);
    assign last_pix = (r_x == eff_w - 1'b1) && (r_y == eff_h - 1'b1);

    // buffer access steering: reads always hit the current buffer
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = win_addr;
        mem_we    = 1'b0;
        mem_waddr = pix_addr;
        mem_wdata = div_quo[PIXEL_BITS-1:0];
        we_a      = 1'b0;
        we_b      = 1'b0;
        if (accept && in_range && (i_cmd == CMD_READ)) begin
            mem_re    = 1'b1;
            mem_raddr = cmd_addr;
        end else if (r_state == S_WIN) begin
            mem_re = 1'b1;
        end
        if (accept && in_range && (i_cmd == CMD_WRITE)) begin
            mem_we    = 1'b1;
            mem_waddr = cmd_addr;
            mem_wdata = PIXEL_BITS'(i_pixel_in);
            we_a      = !r_cur;
            we_b      = r_cur;
        end else if (r_state == S_WB) begin
            mem_we = 1'b1;
            we_a   = r_cur;
            we_b   = !r_cur;
        end
    end

    dwsf_frame_buf #(.DEPTH(DEPTH), .DW(PIXEL_BITS)) u_frame_a (
        .i_clk   (i_clk),
        .i_we    (we_a && mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re && !r_cur),
        .i_raddr (mem_raddr),
        .o_rdata (rd_a)
    );

    dwsf_frame_buf #(.DEPTH(DEPTH), .DW(PIXEL_BITS)) u_frame_b (
        .i_clk   (i_clk),
        .i_we    (we_b && mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re && r_cur),
        .i_raddr (mem_raddr),
        .o_rdata (rd_b)
    );

    assign rd_data = r_cur ? rd_b : rd_a;

    // rounded mean: floor((2*sum + count) / (2*count))
    assign div_num = NW'({r_sum, 1'b0}) + NW'(r_cnt);
    assign div_den = {r_cnt, 1'b0};

    dwsf_div #(.DEN_W(DEN_W), .QB(QB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_WIDTH;
            r_cfg_h <= RST_HEIGHT;
            r_cfg_r <= RST_RADIUS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                CFG_RADIUS: r_cfg_r <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc_v     <= 1'b0;
        end else begin
            // in S_RESP the output register is reloaded below instead
            if (r_out_valid && i_out_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            r_acc_v <= (r_state == S_WIN);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if ((i_cmd == CMD_PASS) && (eff_w != '0) && (eff_h != '0)) begin
                            r_state <= S_PIX;
                        end else begin
                            if (i_cmd == CMD_PASS) begin
                                r_cur <= !r_cur;
                            end
                            r_state <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_PIX:    r_state <= S_WIN;
                S_WIN: begin
                    if (last_win) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN:  r_state <= S_DSTART;
                S_DSTART: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (last_pix) begin
                        r_cur   <= !r_cur;
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_PIX;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_err <= ((i_cmd == CMD_WRITE) || (i_cmd == CMD_READ)) && !in_range;
            r_x   <= '0;
            r_y   <= '0;
        end
        if ((r_state == S_RESP) && out_free) begin
            r_pixel_out <= ((r_cmd == CMD_READ) && !r_err) ? PIX_PORT_W'(rd_data) : '0;
            r_coord_err <= r_err;
        end
        if (r_state == S_PIX) begin
            r_x0  <= x0;
            r_x1m <= x1 - 1'b1;
            r_y1m <= y1 - 1'b1;
            r_i   <= x0;
            r_j   <= y0;
            r_sum <= '0;
            r_cnt <= '0;
        end
        if (r_state == S_WIN) begin
            r_wgt <= WGT_W'(wgt_full);
            if (r_i == r_x1m) begin
                r_i <= r_x0;
                r_j <= r_j + 1'b1;
            end else begin
                r_i <= r_i + 1'b1;
            end
        end
        if (r_acc_v) begin
            r_sum <= r_sum + SUM_W'(r_wgt) * SUM_W'(rd_data);
            r_cnt <= r_cnt + CNT_W'(r_wgt);
        end
        if (r_state == S_WB) begin
            if (r_x == eff_w - 1'b1) begin
                r_x <= '0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_out   = r_pixel_out;
    assign o_coord_error = r_coord_err;

    `DWSF_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n, accept, !o_in_ready)
    `DWSF_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == S_DIV)
    `DWSF_ASSERT_NEVER(a_single_buffer_write, i_clk, i_rst_n, we_a && we_b && mem_we)
    `DWSF_ASSERT_NEXT(a_pass_swaps, i_clk, i_rst_n, (r_state == S_WB) && last_pix,
                      r_cur != $past(r_cur))
    `DWSF_ASSERT_IMP(a_acc_after_read, i_clk, i_rst_n, r_acc_v,
                     (r_state == S_WIN) || (r_state == S_DRAIN))
endmodule
